FILE: design/smds_pkg.sv
// Package for the shared-memory dual stack: operation and status codes,
// controller state type and controller-to-datapath command bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smds_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic SEL_LOWER = 1'b0;
  localparam logic SEL_UPPER = 1'b1;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_EXEC,
    CTL_RESP
  } ctl_state_t;

  typedef struct packed {
    logic load;  // capture the operation being transferred in
    logic exec;  // perform the memory access and update the counts
  } dp_cmd_t;

endpackage

`default_nettype wire

FILE: design/shared_memory_dual_stack.sv
// Top level of the shared-memory dual stack: controller plus datapath.
// Depends on smds_pkg, smds_ctrl, smds_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Two stacks share one memory of DEPTH 32-bit words; the lower stack grows
// up from word 0, the upper one down from word DEPTH-1. Each operation
// (push, pop or peek on the selected stack) has an access cycle on the
// single-port memory, followed by a result cycle in which the result is
// shown with done high, the read data coming from the memory's registered
// read port. busy is high only in the access cycle, so a new operation can
// be transferred in during the result cycle. done is high for exactly one
// cycle per operation and the receiver cannot hold it off. Memory words are
// undefined until pushed.
module shared_memory_dual_stack
  import smds_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         operation,
  input  wire logic               stack_select,
  input  wire logic signed [31:0] push_value,
  output logic                    done,
  output logic      [1:0]         status,
  output logic signed [31:0]      read_value,
  output logic                    lower_empty,
  output logic                    upper_empty,
  output logic                    all_full
);

  dp_cmd_t cmd;

  smds_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .cmd  (cmd)
  );

  smds_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .stack_select(stack_select),
    .push_value  (push_value),
    .status      (status),
    .read_value  (read_value),
    .lower_empty (lower_empty),
    .upper_empty (upper_empty),
    .all_full    (all_full)
  );

endmodule

`default_nettype wire

FILE: design/smds_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module smds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/smds_ctrl.sv
// Controller state machine for the shared-memory dual stack.
// Depends on smds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smds_ctrl
  import smds_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  output logic      done,
  output dp_cmd_t   cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CTL_IDLE: begin
        if (start) begin
          state_next = CTL_EXEC;
        end
      end
      CTL_EXEC: begin
        state_next = CTL_RESP;
      end
      CTL_RESP: begin
        // a new operation may be transferred in while the result is shown
        state_next = start ? CTL_EXEC : CTL_IDLE;
      end
      default: begin
        state_next = CTL_IDLE;
      end
    endcase
  end

  always_comb begin
    busy     = (state == CTL_EXEC);
    done     = (state == CTL_RESP);
    cmd.load = start && (state != CTL_EXEC);
    cmd.exec = (state == CTL_EXEC);
  end

  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.exec)
    else $error("accepted operation not executed next cycle");

  a_exec_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> done)
    else $error("execution not followed by result cycle");

endmodule

`default_nettype wire

FILE: design/smds_datapath.sv
// Datapath for the shared-memory dual stack: operation register, stack
// counts, address selection and the shared word memory.
// Depends on smds_pkg and smds_ram.
`timescale 1ns / 1ps
`default_nettype none

module smds_datapath
  import smds_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  input  wire logic [1:0]         operation,
  input  wire logic               stack_select,
  input  wire logic signed [31:0] push_value,
  output logic      [1:0]         status,
  output logic signed [31:0]      read_value,
  output logic                    lower_empty,
  output logic                    upper_empty,
  output logic                    all_full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  logic [1:0]        op_q;
  logic              sel_q;
  logic [DATA_W-1:0] val_q;
  logic [1:0]        status_q;
  logic              rd_valid;
  logic [CW-1:0]     lower_count;
  logic [CW-1:0]     upper_count;
  logic [CW-1:0]     lower_count_next;
  logic [CW-1:0]     upper_count_next;
  logic [1:0]        status_next;
  logic              rd_valid_next;

  logic              full;
  logic              sel_empty;
  logic              is_push;
  logic              is_read;
  logic              ram_we;
  logic              ram_re;
  logic [CW-1:0]     addr_wide;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      sel_q <= stack_select;
      val_q <= push_value;
    end
  end

  assign full      = ({1'b0, lower_count} + {1'b0, upper_count}) == DEPTH_SUM;
  assign sel_empty = (sel_q == SEL_LOWER) ? (lower_count == '0) : (upper_count == '0);
  assign is_push   = (op_q == OP_PUSH);
  assign is_read   = (op_q == OP_POP) || (op_q == OP_PEEK);
  assign ram_we    = cmd.exec && is_push && !full;
  assign ram_re    = cmd.exec && is_read && !sel_empty;

  // push slot or top slot of the selected stack
  always_comb begin
    if (is_push) begin
      addr_wide = (sel_q == SEL_LOWER) ? lower_count
                                       : DEPTH_CNT - upper_count - CW'(1);
    end else begin
      addr_wide = (sel_q == SEL_LOWER) ? lower_count - CW'(1)
                                       : DEPTH_CNT - upper_count;
    end
  end
  assign ram_addr = addr_wide[AW-1:0];

  always_comb begin
    lower_count_next = lower_count;
    upper_count_next = upper_count;
    status_next      = status_q;
    rd_valid_next    = rd_valid;
    if (cmd.exec) begin
      status_next   = ST_OK;
      rd_valid_next = 1'b0;
      if (is_push) begin
        if (full) begin
          status_next = ST_FULL;
        end else if (sel_q == SEL_LOWER) begin
          lower_count_next = lower_count + CW'(1);
        end else begin
          upper_count_next = upper_count + CW'(1);
        end
      end else if (is_read) begin
        if (sel_empty) begin
          status_next = ST_EMPTY;
        end else begin
          rd_valid_next = 1'b1;
          if (op_q == OP_POP) begin
            if (sel_q == SEL_LOWER) begin
              lower_count_next = lower_count - CW'(1);
            end else begin
              upper_count_next = upper_count - CW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_count <= '0;
      upper_count <= '0;
      status_q    <= ST_OK;
      rd_valid    <= 1'b0;
    end else begin
      lower_count <= lower_count_next;
      upper_count <= upper_count_next;
      status_q    <= status_next;
      rd_valid    <= rd_valid_next;
    end
  end

  smds_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(val_q),
    .rdata(ram_rdata)
  );

  assign status      = status_q;
  assign read_value  = rd_valid ? $signed(ram_rdata) : 32'sd0;
  assign lower_empty = (lower_count == '0);
  assign upper_empty = (upper_count == '0);
  assign all_full    = full;

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, lower_count} + {1'b0, upper_count}) <= DEPTH_SUM)
    else $error("stack counts exceed memory depth");

  a_refused_no_data: assert property (@(posedge clk) disable iff (rst)
    (status_q != ST_OK) |-> !rd_valid)
    else $error("refused operation returned data");

  a_refused_holds_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && ((is_push && full) || (is_read && sel_empty)))
      |=> ($stable(lower_count) && $stable(upper_count)))
    else $error("refused operation changed a stack count");

endmodule

`default_nettype wire
